// ===== src/ppe_pkg.sv =====
// ppe_pkg: shared constants, types and microcode table for the pad poll block
// depends on nothing; used by the interfaces, the axis divider and the top level
package ppe_pkg;

   localparam int BUTTON_COUNT = 16;
   localparam int FULL_SCALE   = 75;
   localparam int BUTTON_W     = 16;
   localparam int SCAN_LEN     = (BUTTON_COUNT < BUTTON_W) ? BUTTON_COUNT : BUTTON_W;
   localparam int SCAN_LAST    = SCAN_LEN - 1;
   localparam int Q_FRAC       = 14;
   localparam int Q_ONE        = 1 << Q_FRAC;
   localparam int DZ_W         = 7;
   localparam int CSR_DATA_W   = 7;

   localparam logic [DZ_W-1:0]        DEAD_ZONE_RESET = 7'd11;

   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_DEAD_ZONE = 1'b0;
   localparam csr_index_type CSR_EVENTS_EN = 1'b1;

   typedef enum logic [2:0] {
      OP_WAIT,
      OP_SCAN,
      OP_PREP,
      OP_DIV,
      OP_SUMMARY,
      OP_ERROR
   } op_type;

   typedef logic [2:0] step_type;
   localparam step_type STEP_WAIT  = 3'd0;
   localparam step_type STEP_ERROR = 3'd7;

   typedef struct packed {
      op_type   op;
      logic     axis_y;
      step_type target;
   } ucode_type;

   typedef struct packed {
      logic load;
      logic step;
   } div_cmd_type;

   typedef struct packed {
      logic               done;
      logic signed [15:0] axis;
   } div_stat_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type uc;
      unique case (step)
         3'd0:    uc = '{op: OP_WAIT,    axis_y: 1'b0, target: STEP_ERROR};
         3'd1:    uc = '{op: OP_SCAN,    axis_y: 1'b0, target: STEP_WAIT};
         3'd2:    uc = '{op: OP_PREP,    axis_y: 1'b0, target: STEP_WAIT};
         3'd3:    uc = '{op: OP_DIV,     axis_y: 1'b0, target: STEP_WAIT};
         3'd4:    uc = '{op: OP_PREP,    axis_y: 1'b1, target: STEP_WAIT};
         3'd5:    uc = '{op: OP_DIV,     axis_y: 1'b1, target: STEP_WAIT};
         3'd6:    uc = '{op: OP_SUMMARY, axis_y: 1'b0, target: STEP_WAIT};
         default: uc = '{op: OP_ERROR,   axis_y: 1'b0, target: STEP_WAIT};
      endcase
      return uc;
   endfunction

endpackage

// ===== src/ppe_if.sv =====
// ppe request, response and csr channel interfaces (valid/ready)
// depends on ppe_pkg for field widths
interface ppe_req_if;
   logic                             valid;
   logic                             ready;
   logic [ppe_pkg::BUTTON_W-1:0]     button_word;
   logic signed [7:0]                stick_x;
   logic signed [7:0]                stick_y;
   logic [7:0]                       error_code;
   modport source (output valid, button_word, stick_x, stick_y, error_code, input ready);
   modport sink   (input valid, button_word, stick_x, stick_y, error_code, output ready);
endinterface

interface ppe_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [3:0]         button_index;
   logic               pressed;
   logic signed [15:0] axis_x;
   logic signed [15:0] axis_y;
   logic               poll_skipped;
   logic               error_bit_three;
   logic               last;
   modport source (output valid, kind, button_index, pressed, axis_x, axis_y,
                   poll_skipped, error_bit_three, last, input ready);
   modport sink   (input valid, kind, button_index, pressed, axis_x, axis_y,
                   poll_skipped, error_bit_three, last, output ready);
endinterface

interface ppe_csr_if;
   logic                               valid;
   logic                               ready;
   ppe_pkg::csr_index_type             index;
   logic [ppe_pkg::CSR_DATA_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/pad_poll_edge_and_deadzone.sv =====
// pad_poll_edge_and_deadzone: gamepad poll to button edge events and normalized stick axes
// depends on ppe_pkg, ppe_if and ppe_axis_div
// One poll enters per transfer on req_port and gives one to seventeen transfers on
// rsp_port. A poll with a nonzero error byte goes to the error step and gives one result.
// A valid poll runs through a microcoded program: capture, then a button scan at one
// bit per cycle when events are enabled, held while a changed bit waits on rsp_port,
// or a single step otherwise, then per axis a setup step and the bit-serial divider,
// then the summary, which waits while rsp_port holds ready low. The csr port is
// always ready and must be written only while idle.
module pad_poll_edge_and_deadzone (
   input  logic      clock,
   input  logic      reset,
   ppe_req_if.sink   req_port,
   ppe_rsp_if.source rsp_port,
   ppe_csr_if.sink   csr_port
);

   ppe_pkg::step_type   step_ff, step_in;
   ppe_pkg::ucode_type  uc;
   ppe_pkg::div_cmd_type  div_cmd;
   ppe_pkg::div_stat_type div_stat;

   logic [ppe_pkg::DZ_W-1:0]     dead_zone_ff;
   logic                         events_en_ff;
   logic [ppe_pkg::BUTTON_W-1:0] btn_ff, prev_btn_ff, diff;
   logic signed [7:0]            sx_ff, sy_ff, div_stick;
   logic                         err3_ff;
   logic [3:0]                   idx_ff, idx_in;
   logic signed [15:0]           ax_ff, ay_ff;

   logic rsp_valid_ff, rsp_kind_ff, rsp_pressed_ff, rsp_skip_ff, rsp_eb3_ff, rsp_last_ff;
   logic [3:0]         rsp_idx_ff;
   logic signed [15:0] rsp_ax_ff, rsp_ay_ff;

   logic req_accept, out_free, hit, scan_move;
   logic emit_event, emit_summary, emit_error, div_finish;

   assign uc   = ppe_pkg::ucode_rom(step_ff);
   assign diff = btn_ff ^ prev_btn_ff;

   // step sequencer: next step
   always_comb begin
      step_in = step_ff;
      idx_in  = idx_ff;
      unique case (uc.op) inside
         ppe_pkg::OP_WAIT: begin
            idx_in = '0;
            if (req_accept) begin
               step_in = (req_port.error_code != 8'd0) ? uc.target : step_ff + 3'd1;
            end
         end
         ppe_pkg::OP_SCAN: begin
            if (!events_en_ff) begin
               step_in = step_ff + 3'd1;
            end else if (scan_move) begin
               idx_in = idx_ff + 4'd1;
               if (idx_ff == 4'(ppe_pkg::SCAN_LAST)) begin
                  step_in = step_ff + 3'd1;
               end
            end
         end
         ppe_pkg::OP_PREP: begin
            step_in = step_ff + 3'd1;
         end
         ppe_pkg::OP_DIV: begin
            if (div_stat.done) begin
               step_in = step_ff + 3'd1;
            end
         end
         ppe_pkg::OP_SUMMARY, ppe_pkg::OP_ERROR: begin
            if (out_free) begin
               step_in = uc.target;
            end
         end
         default: begin
            step_in = ppe_pkg::STEP_WAIT;
         end
      endcase
   end

   // step sequencer: datapath controls
   always_comb begin
      req_port.ready = (uc.op == ppe_pkg::OP_WAIT);
      csr_port.ready = 1'b1;
      req_accept     = req_port.valid && req_port.ready;
      out_free       = !rsp_valid_ff || rsp_port.ready;
      hit            = events_en_ff && diff[idx_ff];
      scan_move      = !hit || out_free;
      emit_event     = (uc.op == ppe_pkg::OP_SCAN) && hit && out_free;
      emit_summary   = (uc.op == ppe_pkg::OP_SUMMARY) && out_free;
      emit_error     = (uc.op == ppe_pkg::OP_ERROR) && out_free;
      div_cmd.load   = (uc.op == ppe_pkg::OP_PREP);
      div_cmd.step   = (uc.op == ppe_pkg::OP_DIV) && !div_stat.done;
      div_finish     = (uc.op == ppe_pkg::OP_DIV) && div_stat.done;
      div_stick      = uc.axis_y ? sy_ff : sx_ff;
   end

   ppe_axis_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .stick     (div_stick),
      .dead_zone (dead_zone_ff),
      .stat      (div_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ppe_pkg::STEP_WAIT;
         idx_ff       <= '0;
         dead_zone_ff <= ppe_pkg::DEAD_ZONE_RESET;
         events_en_ff <= 1'b0;
         prev_btn_ff  <= '0;
         ax_ff        <= '0;
         ay_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         idx_ff  <= idx_in;
         if (csr_port.valid && csr_port.ready) begin
            unique case (csr_port.index)
               ppe_pkg::CSR_DEAD_ZONE: dead_zone_ff <= csr_port.data[ppe_pkg::DZ_W-1:0];
               ppe_pkg::CSR_EVENTS_EN: events_en_ff <= csr_port.data[0];
               default: ;
            endcase
         end
         if (emit_summary) begin
            prev_btn_ff <= btn_ff;
         end
         if (div_finish && !uc.axis_y) begin
            ax_ff <= div_stat.axis;
         end
         if (div_finish && uc.axis_y) begin
            ay_ff <= div_stat.axis;
         end
         if (emit_event || emit_summary || emit_error) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // poll capture and result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         btn_ff  <= req_port.button_word;
         sx_ff   <= req_port.stick_x;
         sy_ff   <= 8'(8'd0 - req_port.stick_y);
         err3_ff <= req_port.error_code[3];
      end
      if (emit_event) begin
         rsp_kind_ff    <= 1'b0;
         rsp_idx_ff     <= idx_ff;
         rsp_pressed_ff <= btn_ff[idx_ff];
         rsp_ax_ff      <= '0;
         rsp_ay_ff      <= '0;
         rsp_skip_ff    <= 1'b0;
         rsp_eb3_ff     <= 1'b0;
         rsp_last_ff    <= 1'b0;
      end else if (emit_summary) begin
         rsp_kind_ff    <= 1'b1;
         rsp_idx_ff     <= '0;
         rsp_pressed_ff <= 1'b0;
         rsp_ax_ff      <= ax_ff;
         rsp_ay_ff      <= ay_ff;
         rsp_skip_ff    <= 1'b0;
         rsp_eb3_ff     <= 1'b0;
         rsp_last_ff    <= 1'b1;
      end else if (emit_error) begin
         rsp_kind_ff    <= 1'b1;
         rsp_idx_ff     <= '0;
         rsp_pressed_ff <= 1'b0;
         rsp_ax_ff      <= '0;
         rsp_ay_ff      <= '0;
         rsp_skip_ff    <= 1'b1;
         rsp_eb3_ff     <= err3_ff;
         rsp_last_ff    <= 1'b1;
      end
   end

   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.kind            = rsp_kind_ff;
   assign rsp_port.button_index    = rsp_idx_ff;
   assign rsp_port.pressed         = rsp_pressed_ff;
   assign rsp_port.axis_x          = rsp_ax_ff;
   assign rsp_port.axis_y          = rsp_ay_ff;
   assign rsp_port.poll_skipped    = rsp_skip_ff;
   assign rsp_port.error_bit_three = rsp_eb3_ff;
   assign rsp_port.last            = rsp_last_ff;

   // an errored poll goes straight to the error step
   a_err_path: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_port.error_code != 8'd0) |=> step_ff == ppe_pkg::STEP_ERROR)
      else $error("errored poll did not take the error step");

   // events never close a poll, skipped polls always do
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (!rsp_kind_ff || rsp_skip_ff) |-> (rsp_last_ff == rsp_kind_ff))
      else $error("last flag inconsistent with result kind");

   // summary axes stay within plus or minus one
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff |->
         rsp_ax_ff <= 16'sd16384 && rsp_ax_ff >= -16'sd16384 &&
         rsp_ay_ff <= 16'sd16384 && rsp_ay_ff >= -16'sd16384)
      else $error("axis out of range");

   // button history only moves when a summary transfer is loaded
   a_prev_update: assert property (@(posedge clock) disable iff (reset)
      !$stable(prev_btn_ff) |-> $past(emit_summary))
      else $error("button history changed outside summary");

endmodule

// ===== src/ppe_axis_div.sv =====
// ppe_axis_div: dead zone removal and restoring q2.14 divide, one quotient bit a cycle
// depends on ppe_pkg
module ppe_axis_div (
   input  logic                       clock,
   input  logic                       reset,
   input  ppe_pkg::div_cmd_type       cmd,
   input  logic signed [7:0]          stick,
   input  logic [ppe_pkg::DZ_W-1:0]   dead_zone,
   output ppe_pkg::div_stat_type      stat
);

   logic signed [8:0] s9, dz9, v, d9;
   logic [8:0]        mag;
   logic [6:0]        div_val;
   logic              sat;

   logic [6:0]  rem_ff, rem_in;
   logic [13:0] quo_ff, quo_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [6:0]  div_ff, div_in;
   logic        neg_ff, neg_in;
   logic        sat_ff, sat_in;

   logic [7:0]  r2;
   logic        ge;
   logic [14:0] mag_q;
   logic [7:0]  r2_sub;

   always_comb begin
      s9  = 9'(stick);
      dz9 = 9'({2'b00, dead_zone});
      if (s9 > dz9) begin
         v = s9 - dz9;
      end else if (s9 < -dz9) begin
         v = s9 + dz9;
      end else begin
         v = '0;
      end
      mag     = v[8] ? 9'(-v) : 9'(v);
      d9      = 9'(ppe_pkg::FULL_SCALE) - dz9;
      div_val = (d9 < 9'sd1) ? 7'd1 : d9[6:0];
      sat     = mag >= {2'b00, div_val};
   end

   always_comb begin
      r2     = {rem_ff, 1'b0};
      ge     = r2 >= {1'b0, div_ff};
      r2_sub = r2 - {1'b0, div_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      div_in = div_ff;
      neg_in = neg_ff;
      sat_in = sat_ff;
      if (cmd.load) begin
         rem_in = mag[6:0];
         quo_in = '0;
         cnt_in = '0;
         div_in = div_val;
         neg_in = v[8];
         sat_in = sat;
      end else if (cmd.step) begin
         rem_in = ge ? r2_sub[6:0] : r2[6:0];
         quo_in = {quo_ff[12:0], ge};
         cnt_in = cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
      sat_ff <= sat_in;
   end

   always_comb begin
      mag_q     = sat_ff ? 15'(ppe_pkg::Q_ONE) : {1'b0, quo_ff};
      stat.done = sat_ff || (cnt_ff == 4'(ppe_pkg::Q_FRAC));
      stat.axis = neg_ff ? 16'(-{1'b0, mag_q}) : {1'b0, mag_q};
   end

endmodule

// ===== test/ppe_checker.sv =====
// ppe_checker: watches the poll, result and csr channels of the pad poll block,
// predicts every result from its own copy of the state and compares in order
// depends on ppe_pkg and the channel interfaces in ppe_if
`timescale 1ns / 100ps
module ppe_checker (
   input  logic clock,
   input  logic reset,
   ppe_req_if   req_mon,
   ppe_rsp_if   rsp_mon,
   ppe_csr_if   csr_mon,
   output int   mismatch_count,
   output int   pending
);

   localparam logic KIND_EVENT   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [3:0]         button_index;
      logic               pressed;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic               poll_skipped;
      logic               error_bit_three;
      logic               last;
   } pad_result_type;

   pad_result_type               pad_results_due[$];
   pad_result_type               got;
   pad_result_type               want;
   logic [ppe_pkg::DZ_W-1:0]     dead_zone;
   logic                         events_on;
   logic [ppe_pkg::BUTTON_W-1:0] last_buttons;
   logic signed [15:0]           held_axis_x;
   logic signed [15:0]           held_axis_y;
   int                           results_seen = 0;
   int                           fail_total = 0;
   int                           queued = 0;

   assign mismatch_count = fail_total;
   assign pending        = queued;

   // dead zone removal, scaling to q2.14 with truncation, clamp to +-1.0
   function automatic logic signed [15:0] normalize_axis(input int stick, input int dz);
      int trimmed;
      int divisor;
      int q;
      if (stick > dz)
         trimmed = stick - dz;
      else if (stick < -dz)
         trimmed = stick + dz;
      else
         trimmed = 0;
      divisor = ppe_pkg::FULL_SCALE - dz;
      if (divisor < 1)
         divisor = 1;
      q = (trimmed * ppe_pkg::Q_ONE) / divisor;
      if (q > ppe_pkg::Q_ONE)
         q = ppe_pkg::Q_ONE;
      else if (q < -ppe_pkg::Q_ONE)
         q = -ppe_pkg::Q_ONE;
      return 16'(q);
   endfunction

   task automatic predict_poll(input logic [ppe_pkg::BUTTON_W-1:0] buttons,
                               input logic signed [7:0] sx,
                               input logic signed [7:0] sy,
                               input logic [7:0]        err);
      pad_result_type               r;
      logic signed [7:0]            flipped_y;
      logic [ppe_pkg::BUTTON_W-1:0] changed;
      int                           i;
      r = '0;
      if (err != 8'd0) begin
         r.kind            = KIND_SUMMARY;
         r.poll_skipped    = 1'b1;
         r.error_bit_three = err[3];
         r.last            = 1'b1;
         pad_results_due.push_back(r);
         return;
      end
      flipped_y = 8'sd0 - sy;
      if (events_on) begin
         changed = buttons ^ last_buttons;
         for (i = 0; i < ppe_pkg::SCAN_LEN; i++) begin
            if (changed[i]) begin
               r              = '0;
               r.kind         = KIND_EVENT;
               r.button_index = 4'(i);
               r.pressed      = buttons[i];
               pad_results_due.push_back(r);
            end
         end
      end
      held_axis_x  = normalize_axis(int'(sx), int'(dead_zone));
      held_axis_y  = normalize_axis(int'(flipped_y), int'(dead_zone));
      last_buttons = buttons;
      r        = '0;
      r.kind   = KIND_SUMMARY;
      r.axis_x = held_axis_x;
      r.axis_y = held_axis_y;
      r.last   = 1'b1;
      pad_results_due.push_back(r);
   endtask

   task automatic report_mismatch(input string what);
      $display("ERROR: result %0d at %0t: %s", results_seen, $realtime, what);
      fail_total++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         dead_zone    = ppe_pkg::DEAD_ZONE_RESET;
         events_on    = 1'b0;
         last_buttons = '0;
         held_axis_x  = '0;
         held_axis_y  = '0;
         pad_results_due.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == ppe_pkg::CSR_DEAD_ZONE)
               dead_zone = csr_mon.data[ppe_pkg::DZ_W-1:0];
            else if (csr_mon.index == ppe_pkg::CSR_EVENTS_EN)
               events_on = csr_mon.data[0];
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{kind: rsp_mon.kind, button_index: rsp_mon.button_index,
                    pressed: rsp_mon.pressed, axis_x: rsp_mon.axis_x,
                    axis_y: rsp_mon.axis_y, poll_skipped: rsp_mon.poll_skipped,
                    error_bit_three: rsp_mon.error_bit_three, last: rsp_mon.last};
            if (pad_results_due.size() == 0) begin
               report_mismatch("result transfer with nothing outstanding");
            end else begin
               want = pad_results_due.pop_front();
               if (got.kind !== want.kind)
                  report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
               if (got.button_index !== want.button_index)
                  report_mismatch($sformatf("button_index got %0d want %0d",
                                            got.button_index, want.button_index));
               if (got.pressed !== want.pressed)
                  report_mismatch($sformatf("pressed got %0d want %0d",
                                            got.pressed, want.pressed));
               if (got.axis_x !== want.axis_x)
                  report_mismatch($sformatf("axis_x got %0d want %0d",
                                            got.axis_x, want.axis_x));
               if (got.axis_y !== want.axis_y)
                  report_mismatch($sformatf("axis_y got %0d want %0d",
                                            got.axis_y, want.axis_y));
               if (got.poll_skipped !== want.poll_skipped)
                  report_mismatch($sformatf("poll_skipped got %0d want %0d",
                                            got.poll_skipped, want.poll_skipped));
               if (got.error_bit_three !== want.error_bit_three)
                  report_mismatch($sformatf("error_bit_three got %0d want %0d",
                                            got.error_bit_three, want.error_bit_three));
               if (got.last !== want.last)
                  report_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
            end
            results_seen++;
         end
         if (req_mon.valid && req_mon.ready)
            predict_poll(req_mon.button_word, req_mon.stick_x, req_mon.stick_y,
                         req_mon.error_code);
      end
      queued <= pad_results_due.size();
   end

endmodule

// ===== test/testbench.sv =====
// testbench: drives polls and register writes into the pad poll block with random
// gaps and result stalls; ppe_checker predicts and compares every result
// depends on ppe_pkg, ppe_if, pad_poll_edge_and_deadzone and ppe_checker
`timescale 1ns / 100ps
module testbench;

   localparam int CYCLE_LIMIT = 600000;

   typedef logic [ppe_pkg::BUTTON_W-1:0]   pad_buttons_type;
   typedef logic [ppe_pkg::CSR_DATA_W-1:0] csr_data_type;

   logic            clock;
   logic            reset;
   int              mismatch_count;
   int              pending;
   int              cycle_count = 0;
   logic            req_quiet = 1'b0;
   pad_buttons_type sent_buttons = '0;

   ppe_req_if req_ch ();
   ppe_rsp_if rsp_ch ();
   ppe_csr_if csr_ch ();

   pad_poll_edge_and_deadzone u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   ppe_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_mon        (csr_ch),
      .mismatch_count (mismatch_count),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result side stalls, with stretches of full throughput
   initial begin : rsp_pacing
      int   stall;
      int   left_in_mode;
      logic no_stall;
      rsp_ch.ready <= 1'b0;
      left_in_mode = 0;
      no_stall     = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (left_in_mode == 0) begin
            no_stall     = ($urandom_range(0, 3) == 0);
            left_in_mode = $urandom_range(8, 40);
         end
         left_in_mode--;
         stall = no_stall ? 0 : $urandom_range(0, 16);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clock);
      end
   end

   task automatic send_poll(input pad_buttons_type   buttons,
                            input logic signed [7:0] sx,
                            input logic signed [7:0] sy,
                            input logic [7:0]        err);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.button_word <= buttons;
      req_ch.stick_x     <= sx;
      req_ch.stick_y     <= sy;
      req_ch.error_code  <= err;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (err == 8'd0)
         sent_buttons = buttons;
   endtask

   task automatic write_reg(input ppe_pkg::csr_index_type idx, input int value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= csr_data_type'(value);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // stick value at or just around the dead zone edge, either sign
   function automatic logic signed [7:0] near_dead_zone(input int dz);
      int v;
      v = dz + $urandom_range(0, 2) - 1;
      return 8'($urandom_range(0, 1) ? v : -v);
   endfunction

   initial begin
      int                phase;
      int                dz;
      pad_buttons_type   buttons;
      logic signed [7:0] sx;
      logic signed [7:0] sy;
      logic [7:0]        err;

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.button_word <= '0;
      req_ch.stick_x     <= '0;
      req_ch.stick_y     <= '0;
      req_ch.error_code  <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= ppe_pkg::CSR_DEAD_ZONE;
      csr_ch.data        <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: events off, dead zone 11
      send_poll(16'h0000, 8'sd0, 8'sd0, 8'h00);
      send_poll(16'hFFFF, 8'sd127, -8'sd128, 8'h00);
      send_poll(16'h0000, -8'sd128, 8'sd127, 8'h08);
      send_poll(16'h1234, 8'sd11, -8'sd11, 8'hF7);
      send_poll(16'hFFFF, 8'sd12, -8'sd12, 8'h00);
      wait_idle();

      write_reg(ppe_pkg::CSR_EVENTS_EN, 1);
      write_reg(ppe_pkg::CSR_DEAD_ZONE, 0);
      send_poll(16'h0000, 8'sd1, -8'sd1, 8'h00);
      send_poll(16'hFFFF, -8'sd128, 8'sd127, 8'h00);
      send_poll(16'h0000, 8'sd0, 8'sd0, 8'hFF);
      send_poll(16'hFFFF, 8'sd0, 8'sd0, 8'h00);
      send_poll(16'h8001, 8'sd75, -8'sd75, 8'h00);
      send_poll(16'h8000, 8'sd74, -8'sd74, 8'h00);
      wait_idle();

      write_reg(ppe_pkg::CSR_DEAD_ZONE, 74);
      send_poll(16'h0001, 8'sd74, -8'sd74, 8'h00);
      send_poll(16'h0003, 8'sd75, -8'sd75, 8'h00);
      send_poll(16'h0002, 8'sd127, -8'sd128, 8'h00);
      wait_idle();

      write_reg(ppe_pkg::CSR_DEAD_ZONE, 75);
      send_poll(16'hAAAA, 8'sd76, -8'sd76, 8'h00);
      send_poll(16'h5555, 8'sd75, 8'sd75, 8'h00);
      wait_idle();

      write_reg(ppe_pkg::CSR_DEAD_ZONE, 127);
      send_poll(16'h0F0F, 8'sd127, -8'sd128, 8'h00);
      send_poll(16'hF0F0, -8'sd127, 8'sd0, 8'h80);
      send_poll(16'hF0F0, -8'sd128, 8'sd127, 8'h00);
      wait_idle();

      for (phase = 0; phase < 6; phase++) begin
         case ($urandom_range(0, 4))
            0:       dz = 0;
            1:       dz = 74;
            2:       dz = $urandom_range(75, 127);
            default: dz = $urandom_range(1, 73);
         endcase
         write_reg(ppe_pkg::CSR_DEAD_ZONE, dz);
         write_reg(ppe_pkg::CSR_EVENTS_EN, ($urandom_range(0, 3) != 0) ? 1 : 0);
         req_quiet = ($urandom_range(0, 2) == 0);
         repeat (60) begin
            err = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
            if ($urandom_range(0, 2) == 0)
               buttons = pad_buttons_type'($urandom);
            else
               buttons = sent_buttons
                         ^ (pad_buttons_type'(1) << $urandom_range(0, 15))
                         ^ (pad_buttons_type'(1) << $urandom_range(0, 15));
            sx = $urandom_range(0, 2) == 0 ? near_dead_zone(dz) : 8'($urandom);
            sy = $urandom_range(0, 2) == 0 ? near_dead_zone(dz) : 8'($urandom);
            send_poll(buttons, sx, sy, err);
         end
         wait_idle();
      end

      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && pending == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
